>>> src/tfb_pkg.sv
package tfb_pkg;

    // Field widths of the frame builder.
    localparam int CNT_W  = 5;
    localparam int BYTE_W = 8;
    localparam int VAL_W  = 16;

    // Word count after reset.
    localparam logic [CNT_W-1:0] WORD_COUNT_RESET = 5'd10;

    // Fixed header sync bytes.
    localparam logic [BYTE_W-1:0] SYNC0_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC1_BYTE = 8'hFF;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // One classified word as handed from the front to the back.
    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [BYTE_W-1:0] func_code;
        logic [BYTE_W-1:0] len_byte;
        logic              first;
        logic              last;
    } tfb_entry_t;

    // Byte position within the bytes that one word produces.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SYNC0,
        PH_SYNC1,
        PH_FUNC,
        PH_LEN,
        PH_LO,
        PH_HI,
        PH_SUM,
        PH_ADD
    } tfb_phase_t;

endpackage

>>> src/telemetry_frame_builder.sv
// An accepted word goes into the queue; its bytes then move through the output register.
// A word yields two bytes, plus four header bytes when first in a frame and two check bytes
// when last; the back end feeds the one-byte output register each cycle it is free or taken.
// A four-entry queue lets the front accept words while the back end is still sending.
// Reset clears the queue, the frame position and the checks; word_count returns to 10.
module telemetry_frame_builder
    import tfb_pkg::*;
#(
    parameter int MAX_WORDS = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [VAL_W-1:0]  value,
    input  logic [BYTE_W-1:0] function_code,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              frame_end,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data
);

    logic       push;
    tfb_entry_t push_entry;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    tfb_entry_t head_entry;

    // Front end: accepts and classifies words.
    tfb_front #(
        .MAX_WORDS(MAX_WORDS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .function_code(function_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .push         (push),
        .push_entry   (push_entry),
        .queue_full   (queue_full)
    );

    // Queue between front and back.
    tfb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .full      (queue_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_entry(head_entry)
    );

    // Back end: serializes bytes and keeps the checks.
    tfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head_entry(head_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

endmodule

>>> src/tfb_front.sv
module tfb_front
    import tfb_pkg::*;
#(
    parameter int MAX_WORDS = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [VAL_W-1:0]  value,
    input  logic [BYTE_W-1:0] function_code,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,
    output logic              push,
    output tfb_entry_t        push_entry,
    input  logic              queue_full
);

    // Largest count the register can take effect with.
    localparam int CAP_INT = (MAX_WORDS > ((1 << CNT_W) - 1)) ? ((1 << CNT_W) - 1) : MAX_WORDS;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_INT);

    logic [CNT_W-1:0] word_count_reg;
    logic [CNT_W-1:0] word_count_next;
    logic [CNT_W-1:0] word_index_reg;
    logic [CNT_W-1:0] word_index_next;
    logic [CNT_W-1:0] eff_count;
    logic [CNT_W-1:0] index_inc;
    logic             is_last;

    assign in_ready  = !queue_full;
    assign cfg_ready = 1'b1;
    assign push      = in_valid && !queue_full;

    // Effective frame length: zero acts as one, large values saturate.
    always_comb
    begin
        if (word_count_reg == '0)
            eff_count = CNT_W'(1);
        else if (word_count_reg > CAP)
            eff_count = CAP;
        else
            eff_count = word_count_reg;
    end

    assign index_inc = word_index_reg + CNT_W'(1);
    assign is_last   = (index_inc >= eff_count);

    // Classify the incoming word.
    always_comb
    begin
        push_entry.value     = value;
        push_entry.func_code = function_code;
        push_entry.len_byte  = {2'b00, eff_count, 1'b0};
        push_entry.first     = (word_index_reg == '0);
        push_entry.last      = is_last;
    end

    // Word position and count register; a write mid-frame is ignored.
    always_comb
    begin
        word_index_next = word_index_reg;
        word_count_next = word_count_reg;
        if (push)
            word_index_next = is_last ? '0 : index_inc;
        if (cfg_valid && (word_index_reg == '0))
            word_count_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= WORD_COUNT_RESET;
            word_index_reg <= '0;
        end
        else
        begin
            word_count_reg <= word_count_next;
            word_index_reg <= word_index_next;
        end
    end

endmodule

>>> src/tfb_fifo.sv
module tfb_fifo
    import tfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tfb_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output tfb_entry_t head_entry
);

    tfb_entry_t        entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_pop;

    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (do_pop && !push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> src/tfb_back.sv
module tfb_back
    import tfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  tfb_entry_t        head_entry,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              frame_end
);

    tfb_phase_t        phase_reg;
    tfb_phase_t        phase_next;
    tfb_phase_t        phase_cur;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [BYTE_W-1:0] add_reg;
    logic [BYTE_W-1:0] add_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic              frame_end_reg;
    logic              frame_end_next;
    logic              advance;
    logic [BYTE_W-1:0] cur_byte;
    logic              cur_checked;
    logic              cur_end;
    logic [BYTE_W-1:0] sum_step;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;

    // A byte moves into the output register when it is free or being taken.
    assign advance = head_valid && (!out_valid_reg || out_ready);

    // Position of the byte to send; a fresh entry starts at its first byte.
    always_comb
    begin
        if (phase_reg == PH_IDLE)
            phase_cur = head_entry.first ? PH_SYNC0 : PH_LO;
        else
            phase_cur = phase_reg;
    end

    // Next byte position.
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            case (phase_cur)
                PH_SYNC0: phase_next = PH_SYNC1;
                PH_SYNC1: phase_next = PH_FUNC;
                PH_FUNC:  phase_next = PH_LEN;
                PH_LEN:   phase_next = PH_LO;
                PH_LO:    phase_next = PH_HI;
                PH_HI:    phase_next = head_entry.last ? PH_SUM : PH_IDLE;
                PH_SUM:   phase_next = PH_ADD;
                PH_ADD:   phase_next = PH_IDLE;
                default:  phase_next = PH_IDLE;
            endcase
        end
    end

    // Byte selection and pop for the current position.
    always_comb
    begin
        cur_byte    = head_entry.value[7:0];
        cur_checked = 1'b1;
        cur_end     = 1'b0;
        pop         = 1'b0;
        case (phase_cur)
            PH_SYNC0: cur_byte = SYNC0_BYTE;
            PH_SYNC1: cur_byte = SYNC1_BYTE;
            PH_FUNC:  cur_byte = head_entry.func_code;
            PH_LEN:   cur_byte = head_entry.len_byte;
            PH_LO:    cur_byte = head_entry.value[7:0];
            PH_HI:
            begin
                cur_byte = head_entry.value[15:8];
                pop      = advance && !head_entry.last;
            end
            PH_SUM:
            begin
                cur_byte    = sum_reg;
                cur_checked = 1'b0;
            end
            PH_ADD:
            begin
                cur_byte    = add_reg;
                cur_checked = 1'b0;
                cur_end     = 1'b1;
                pop         = advance;
            end
            default:
            begin
                cur_byte    = '0;
                cur_checked = 1'b0;
            end
        endcase
    end

    // Running checks; the first sync byte restarts both sums.
    assign sum_step = ((phase_cur == PH_SYNC0) ? '0 : sum_reg) + cur_byte;

    always_comb
    begin
        sum_next = sum_reg;
        add_next = add_reg;
        if (advance && cur_checked)
        begin
            sum_next = sum_step;
            add_next = ((phase_cur == PH_SYNC0) ? '0 : add_reg) + sum_step;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        frame_end_next = frame_end_reg;
        if (!out_valid_reg || out_ready)
        begin
            out_valid_next = head_valid;
            out_byte_next  = cur_byte;
            frame_end_next = cur_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            sum_reg       <= '0;
            add_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            add_reg       <= add_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        frame_end_reg <= frame_end_next;
    end

endmodule

>>> test/tb.sv
module tb;
    import tfb_pkg::*;

    localparam int MAX_WORDS   = 20;
    localparam int RANDOM_WORDS = 130;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_IDLE    = 18;

    // Function codes that telemetry frames normally carry.
    localparam logic [BYTE_W-1:0] FUNC_CODE_A = 8'hF1;
    localparam logic [BYTE_W-1:0] FUNC_CODE_B = 8'hF2;

    // One expected byte on the output channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_byte_t;

    // Tracks the frame position and the two check sums, and holds the bytes still to come.
    class frame_byte_tracker;
        logic [CNT_W-1:0]  word_count = WORD_COUNT_RESET;
        logic [CNT_W-1:0]  word_index = '0;
        logic [BYTE_W-1:0] sum_acc    = '0;
        logic [BYTE_W-1:0] add_acc    = '0;
        frame_byte_t       expected_bytes[$];
        int                mismatches = 0;

        // A count of zero acts as one, and counts above the maximum saturate.
        function logic [CNT_W-1:0] frame_length();
            if (word_count == '0)
                return CNT_W'(1);
            if (word_count > MAX_WORDS)
                return CNT_W'(MAX_WORDS);
            return word_count;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // The register only takes a write between frames.
        function void write_count(logic [CNT_W-1:0] count);
            if (word_index == '0)
                word_count = count;
        endfunction

        function void push_byte(logic [BYTE_W-1:0] data, logic last);
            frame_byte_t entry;
            entry.data = data;
            entry.last = last;
            expected_bytes.push_back(entry);
        endfunction

        // Bytes that enter both check sums.
        function void push_summed(logic [BYTE_W-1:0] data);
            sum_acc = sum_acc + data;
            add_acc = add_acc + sum_acc;
            push_byte(data, 1'b0);
        endfunction

        // Works out every byte that one accepted word causes.
        function void take_word(logic [VAL_W-1:0] word, logic [BYTE_W-1:0] func);
            logic [CNT_W-1:0] n;
            n = frame_length();
            if (word_index == '0)
            begin
                sum_acc = '0;
                add_acc = '0;
                push_summed(SYNC0_BYTE);
                push_summed(SYNC1_BYTE);
                push_summed(func);
                push_summed({2'b00, n, 1'b0});
            end
            push_summed(word[7:0]);
            push_summed(word[15:8]);
            word_index = word_index + 1'b1;
            if (word_index >= n)
            begin
                push_byte(sum_acc, 1'b0);
                push_byte(add_acc, 1'b1);
                word_index = '0;
                sum_acc    = '0;
                add_acc    = '0;
            end
        endfunction

        // Compares one transferred byte with the oldest expected one.
        function void match_byte(logic [BYTE_W-1:0] data, logic last);
            frame_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected byte %02h (frame_end %0b) with nothing pending", data, last);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data)
            begin
                $error("out_byte: expected %02h, actual %02h", want.data, data);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("frame_end: expected %0b, actual %0b", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [VAL_W-1:0]  value;
    logic [BYTE_W-1:0] function_code;
    logic              out_valid;
    logic              out_ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;

    frame_byte_tracker tracker = new;
    int                cycle_count = 0;
    int                rx_hold = 0;
    bit                tx_quiet = 1'b0;
    bit                rx_quiet = 1'b0;

    telemetry_frame_builder #(
        .MAX_WORDS(MAX_WORDS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .function_code(function_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .frame_end    (frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit in case a transfer never comes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Output monitor: checks each byte transfer and draws the next stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.match_byte(out_byte, frame_end);
            rx_hold = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        end
    end

    // Receiver: holds ready low for the drawn number of cycles before each byte.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Sends one word after a random gap and returns at its transfer.
    task automatic send_word(logic [VAL_W-1:0] word, logic [BYTE_W-1:0] func);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        value         <= word;
        function_code <= func;
        in_valid      <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        tracker.take_word(word, func);
    endtask

    // Stops sending and waits until every expected byte has been transferred.
    task automatic drain_frames();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the word count once the block has gone quiet.
    task automatic write_count(logic [CNT_W-1:0] count);
        drain_frames();
        @(negedge clk);
        cfg_data  <= count;
        cfg_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        tracker.write_count(count);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] pick_func();
        case ($urandom_range(0, 3))
            0:       return FUNC_CODE_A;
            1:       return FUNC_CODE_B;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // 31, then MAX_WORDS; later mostly short, the odd zero, long and saturating count.
    function automatic logic [CNT_W-1:0] pick_count(int phase);
        int roll;
        if (phase == 0)
            return CNT_W'(31);
        if (phase == 1)
            return CNT_W'(MAX_WORDS);
        roll = $urandom_range(0, 19);
        if (roll < 12)
            return CNT_W'($urandom_range(1, 4));
        if (roll < 15)
            return CNT_W'(0);
        if (roll < 17)
            return CNT_W'($urandom_range(5, MAX_WORDS - 1));
        if (roll < 18)
            return CNT_W'(MAX_WORDS);
        return CNT_W'($urandom_range(MAX_WORDS + 1, 31));
    endfunction

    initial
    begin
        int sent;
        int phase;
        int burst;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        value         = '0;
        function_code = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // One frame at the count that reset leaves.
        for (int i = 0; i < 10; i++)
            send_word(VAL_W'($urandom_range(0, 65535)), (i == 0) ? FUNC_CODE_A : pick_func());

        // One-word frames with the field extremes and both usual codes.
        write_count(CNT_W'(1));
        send_word(16'h0000, 8'h00);
        send_word(16'hFFFF, 8'hFF);
        send_word(16'h00FF, FUNC_CODE_A);
        send_word(16'hFF00, FUNC_CODE_B);

        // A count of zero behaves as one.
        write_count(CNT_W'(0));
        send_word(16'h1234, FUNC_CODE_B);

        // A write in the middle of a frame is dropped.
        write_count(CNT_W'(2));
        send_word(16'hA5C3, 8'h5A);
        write_count(CNT_W'(5));
        send_word(16'h3C5A, 8'h11);

        // Random phases; a phase may end in the middle of a frame.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            write_count(pick_count(phase));
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(1, 2 * tracker.frame_length());
            for (int i = 0; i < burst; i++)
            begin
                send_word(VAL_W'($urandom_range(0, 65535)), pick_func());
                sent++;
            end
            phase++;
        end

        drain_frames();
        repeat (20) @(posedge clk);
        if (tracker.pending() != 0)
        begin
            $error("%0d expected bytes never arrived", tracker.pending());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
src/tfb_pkg.sv
src/tfb_front.sv
src/tfb_fifo.sv
src/tfb_back.sv
src/telemetry_frame_builder.sv
test/tb.sv
